>>> hw/rtl/lom_pkg.sv
`default_nettype none
package lom_pkg;
  localparam logic [1:0] STATUS_NEW     = 2'd0;
  localparam logic [1:0] STATUS_FILL    = 2'd1;
  localparam logic [1:0] STATUS_PARTIAL = 2'd2;
  localparam logic       SIDE_BUY  = 1'b0;
  localparam logic       SIDE_SELL = 1'b1;
  localparam int PRICE_W = 16;
  localparam int QTY_W   = 24;
  localparam int TAG_W   = 32;
  localparam int ARR_W   = 32;

  typedef struct packed {
    logic [TAG_W-1:0]   client_tag;
    logic [TAG_W-1:0]   system_tag;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   quantity;
    logic [1:0]         status;
    logic               rested;
    logic               last;
  } report_t;
endpackage
`default_nettype wire

>>> hw/rtl/limit_order_matcher.sv
`default_nettype none
// Channel  | Signals                                         | Handshake
// order    | order_side/price/quantity, client/system_tag    | start & !busy
// report   | report_* , rested_remainder, last_report        | report_strobe, one cycle
// One slot a cycle through a shared compare unit fed by a registered slot read;
// N = ORDER_CAPACITY+1 slots. Each match costs a sweep of all N slots, a drain and a read
// state, then one report. An order that rests adds one more sweep, a free-slot pass over
// all N slots and its report; an overflow then adds one or two victim sweeps.
// A zero quantity goes straight to its single report.
// Synchronous reset empties the book and zeroes the arrival counter.
// Reports cannot be stalled; busy stays high until the last report and any drop are done.
module limit_order_matcher #(
  parameter int ORDER_CAPACITY = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire                          order_side,
  input  wire [lom_pkg::PRICE_W-1:0]   order_price,
  input  wire [lom_pkg::QTY_W-1:0]     order_quantity,
  input  wire [lom_pkg::TAG_W-1:0]     client_tag,
  input  wire [lom_pkg::TAG_W-1:0]     system_tag,
  output logic                         report_strobe,
  output logic [lom_pkg::TAG_W-1:0]    report_client_tag,
  output logic [lom_pkg::TAG_W-1:0]    report_system_tag,
  output logic                         report_side,
  output logic [lom_pkg::PRICE_W-1:0]  report_price,
  output logic [lom_pkg::QTY_W-1:0]    report_quantity,
  output logic [1:0]                   report_status,
  output logic                         rested_remainder,
  output logic                         last_report
);
  localparam int NSLOT = ORDER_CAPACITY + 1;
  localparam int IDX_W = $clog2(NSLOT);
  localparam int CNT_W = $clog2(NSLOT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NSLOT - 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MSCAN  = 4'd1;
  localparam logic [3:0] ST_MREAD  = 4'd2;
  localparam logic [3:0] ST_MEXEC  = 4'd3;
  localparam logic [3:0] ST_FREE   = 4'd4;
  localparam logic [3:0] ST_DSCAN  = 4'd5;
  localparam logic [3:0] ST_DDONE  = 4'd6;
  localparam logic [3:0] ST_REST   = 4'd7;
  localparam logic [3:0] ST_SCLR   = 4'd8;
  localparam logic [3:0] ST_MDRAIN = 4'd9;
  localparam logic [3:0] ST_DDRAIN = 4'd10;

  logic [3:0] state;
  logic [NSLOT-1:0] slot_valid;
  logic                        mem_side  [NSLOT];
  logic [lom_pkg::PRICE_W-1:0] mem_price [NSLOT];
  logic [lom_pkg::QTY_W-1:0]   mem_qty   [NSLOT];
  logic [lom_pkg::ARR_W-1:0]   mem_arr   [NSLOT];
  logic [lom_pkg::ARR_W-1:0]   arrival_counter;

  logic                        o_side;
  logic [lom_pkg::PRICE_W-1:0] o_price;
  logic [lom_pkg::TAG_W-1:0]   o_ctag, o_stag;
  logic [lom_pkg::QTY_W-1:0]   left;
  logic                        executed;
  logic [CNT_W-1:0]            nmatch;
  logic [IDX_W-1:0]            idx;
  logic                        drop_side;
  logic                        scan_clear, scan_en, scan_drop, scan_side;
  logic                        found;
  logic [IDX_W-1:0]            best;
  logic [lom_pkg::QTY_W-1:0]   b_qty;
  logic [lom_pkg::PRICE_W-1:0] b_price;
  logic [IDX_W-1:0]            free_idx;
  logic                        free_found;
  lom_pkg::report_t            rep;

  // Registered slot read for the scan; the compare works on the slot that idx named in the cycle before.
  logic                        rd_valid;
  logic                        rd_side;
  logic [lom_pkg::PRICE_W-1:0] rd_price;
  logic [lom_pkg::ARR_W-1:0]   rd_arr;
  logic [IDX_W-1:0]            idx_q;
  logic                        scan_en_q;
  logic [lom_pkg::ARR_W-1:0]   r_age;

  always_ff @(posedge clk) begin
    rd_valid <= slot_valid[idx];
    rd_side  <= mem_side[idx];
    rd_price <= mem_price[idx];
    rd_arr   <= mem_arr[idx];
    idx_q    <= idx;
    if (rst) begin
      scan_en_q <= 1'b0;
    end else begin
      scan_en_q <= scan_en;
    end
  end

  assign r_age = arrival_counter - rd_arr;

  assign scan_drop = (state == ST_DSCAN) || (state == ST_DDRAIN);
  assign scan_side = scan_drop ? drop_side : o_side;
  assign scan_en   = (state == ST_MSCAN) || (state == ST_DSCAN);

  lom_scan #(.IDX_W(IDX_W)) u_scan (
    .clk(clk), .clear(scan_clear), .enable(scan_en_q), .mode_drop(scan_drop),
    .side(scan_side), .limit(o_price), .idx(idx_q), .s_valid(rd_valid),
    .s_side(rd_side), .s_price(rd_price), .s_age(r_age), .found(found), .best(best)
  );

  assign busy = (state != ST_IDLE);
  assign scan_clear = (state == ST_IDLE) || (state == ST_MEXEC) || (state == ST_SCLR);

  logic [lom_pkg::QTY_W-1:0] m;
  assign m = (left < b_qty) ? left : b_qty;

  always_ff @(posedge clk) begin
    report_strobe <= 1'b0;
    if (rst) begin
      state           <= ST_IDLE;
      slot_valid      <= '0;
      arrival_counter <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            o_side   <= order_side;
            o_price  <= order_price;
            left     <= order_quantity;
            o_ctag   <= client_tag;
            o_stag   <= system_tag;
            executed <= 1'b0;
            nmatch   <= '0;
            idx      <= '0;
            state    <= (order_quantity == '0) ? ST_REST : ST_MSCAN;
          end
        end
        ST_MSCAN: begin
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= ST_MDRAIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_MDRAIN: begin
          state <= ST_MREAD;
        end
        ST_MREAD: begin
          if (found) begin
            b_qty   <= mem_qty[best];
            b_price <= mem_price[best];
            state   <= ST_MEXEC;
          end else begin
            free_found <= 1'b0;
            state      <= executed ? ST_FREE : (left != '0 ? ST_FREE : ST_REST);
          end
        end
        ST_MEXEC: begin
          left          <= left - m;
          mem_qty[best] <= b_qty - m;
          if (b_qty == m) slot_valid[best] <= 1'b0;
          executed      <= 1'b1;
          nmatch        <= nmatch + 1'b1;
          report_strobe <= 1'b1;
          report_price  <= b_price;
          report_quantity <= m;
          report_status <= (left == m) ? lom_pkg::STATUS_FILL : lom_pkg::STATUS_PARTIAL;
          rested_remainder <= 1'b0;
          last_report   <= (left == m) || (CNT_W'(nmatch + 1'b1) == CNT_W'(NSLOT) &&
                           1'b0);
          if (left == m) begin
            state <= ST_IDLE;
          end else if (CNT_W'(nmatch + 1'b1) == CNT_W'(NSLOT)) begin
            free_found <= 1'b0;
            state      <= ST_FREE;
          end else begin
            state <= ST_MSCAN;
          end
        end
        ST_FREE: begin
          // First free slot, then rest the order and check overflow.
          if (!free_found && !slot_valid[idx]) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= ST_REST;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_REST: begin
          report_strobe    <= 1'b1;
          report_price     <= o_price;
          report_quantity  <= left;
          report_status    <= executed ? lom_pkg::STATUS_PARTIAL : lom_pkg::STATUS_NEW;
          rested_remainder <= executed;
          last_report      <= 1'b1;
          if (left != '0 && (free_found || !slot_valid[idx])) begin
            // free_found always set when a slot is free; only book full leaves it clear
            slot_valid[free_idx] <= 1'b1;
            mem_side[free_idx]   <= o_side;
            mem_price[free_idx]  <= o_price;
            mem_qty[free_idx]    <= left;
            mem_arr[free_idx]    <= arrival_counter;
            arrival_counter      <= arrival_counter + 1'b1;
            if ($countones(slot_valid) == ORDER_CAPACITY) begin
              drop_side <= lom_pkg::SIDE_BUY;
              idx       <= '0;
              state     <= ST_SCLR;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SCLR: begin
          idx   <= '0;
          state <= ST_DSCAN;
        end
        ST_DSCAN: begin
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= ST_DDRAIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DDRAIN: begin
          state <= ST_DDONE;
        end
        ST_DDONE: begin
          if (found) begin
            slot_valid[best] <= 1'b0;
            state <= ST_IDLE;
          end else if (drop_side == lom_pkg::SIDE_BUY) begin
            drop_side <= lom_pkg::SIDE_SELL;
            state     <= ST_SCLR;
          end else begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    rep.client_tag = o_ctag;
    rep.system_tag = o_stag;
    rep.side       = o_side;
    rep.price      = report_price;
    rep.quantity   = report_quantity;
    rep.status     = report_status;
    rep.rested     = rested_remainder;
    rep.last       = last_report;
  end
  assign report_client_tag = rep.client_tag;
  assign report_system_tag = rep.system_tag;
  assign report_side       = rep.side;
endmodule
`default_nettype wire

>>> hw/rtl/lom_scan.sv
`default_nettype none
// Compare unit: one slot a cycle, while enable is high, against the running candidate.
module lom_scan #(
  parameter int IDX_W = 6
) (
  input  wire                              clk,
  input  wire                              clear,
  input  wire                              enable,
  input  wire                              mode_drop,
  input  wire                              side,
  input  wire [lom_pkg::PRICE_W-1:0]       limit,
  input  wire [IDX_W-1:0]                  idx,
  input  wire                              s_valid,
  input  wire                              s_side,
  input  wire [lom_pkg::PRICE_W-1:0]       s_price,
  input  wire [lom_pkg::ARR_W-1:0]         s_age,
  output logic                             found,
  output logic [IDX_W-1:0]                 best
);
  logic [lom_pkg::PRICE_W-1:0] best_price;
  logic [lom_pkg::ARR_W-1:0]   best_age;
  logic eligible, better;

  always_comb begin
    if (mode_drop) begin
      eligible = s_valid && (s_side == side);
      if (!found) better = 1'b1;
      else if (s_price != best_price)
        better = (side == lom_pkg::SIDE_BUY) ? (s_price < best_price) : (s_price > best_price);
      else better = s_age < best_age;
    end else begin
      eligible = s_valid && (s_side != side) &&
                 ((side == lom_pkg::SIDE_BUY) ? (s_price <= limit) : (s_price >= limit));
      if (!found) better = 1'b1;
      else if (s_price != best_price)
        better = (side == lom_pkg::SIDE_BUY) ? (s_price < best_price) : (s_price > best_price);
      else better = s_age > best_age;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      found <= 1'b0;
    end else if (enable && eligible && better) begin
      found      <= 1'b1;
      best       <= idx;
      best_price <= s_price;
      best_age   <= s_age;
    end
  end
endmodule
`default_nettype wire
